// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

  // Heap geometry and table sizes.
  localparam int HEAP_BYTES   = 1048576;
  localparam int HEADER_BYTES = 16;
  localparam int FREE_SLOTS   = 16;
  localparam int RECORD_SLOTS = 32;
  localparam int ALIGN_MASK   = 7;

  // Payload field widths.
  localparam int FUNC_W   = 2;
  localparam int REQ_W    = 21;
  localparam int PTR_W    = 21;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 20;
  localparam int LEN_W    = 21;

  // Internal widths.
  localparam int START_W = $clog2(HEAP_BYTES);
  localparam int NEED_W  = REQ_W + 1;
  localparam int SUM_W   = ((START_W > LEN_W) ? START_W : LEN_W) + 2;
  localparam int FCNT_W  = $clog2(FREE_SLOTS + 1);
  localparam int RIDX_W  = $clog2(RECORD_SLOTS);
  localparam int SCAN_W  = $clog2((RECORD_SLOTS > FREE_SLOTS) ? RECORD_SLOTS : FREE_SLOTS);

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DOUBLE  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd5;

  // Record states.
  localparam logic [1:0] REC_UNUSED = 2'd0;
  localparam logic [1:0] REC_LIVE   = 2'd1;
  localparam logic [1:0] REC_FREED  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REQ_W-1:0]  req_bytes;
    logic [PTR_W-1:0]  ptr;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    granted_bytes;
    logic [LEN_W-1:0]    largest_free;
  } out_item_t;

  // One free extent: header offset and payload length.
  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } ext_t;

  // One allocation record.
  typedef struct packed {
    logic [1:0]         status;
    logic [START_W-1:0] addr;
    logic [LEN_W-1:0]   len;
  } rec_t;

  // Per-cell control of the record ring.
  typedef struct packed {
    logic shift;
    logic write;
  } rec_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FSEARCH,
    S_FCHECK,
    S_RSEARCH,
    S_DECIDE,
    S_FEDIT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/ffha_in_if.sv =====
interface ffha_in_if import ffha_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ffha_out_if.sv =====
interface ffha_out_if import ffha_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ffha_free_cell.sv =====
module ffha_free_cell import ffha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  ext_t init,
  input  logic shift,
  input  ext_t nbr,
  output ext_t ext
);

  // Take the neighbor's extent on every shift; reset loads the heap's initial view.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext <= init;
    end else if (shift) begin
      ext <= nbr;
    end
  end

endmodule

// ===== rtl/ffha_rec_cell.sv =====
module ffha_rec_cell import ffha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rec_ctl_t ctl,
  input  rec_t     nbr,
  input  rec_t     wr_data,
  output rec_t     rec
);

  logic [1:0]         status;
  logic [START_W-1:0] addr;
  logic [LEN_W-1:0]   len;

  // Record state starts out unused.
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= REC_UNUSED;
    end else if (ctl.write) begin
      status <= wr_data.status;
    end else if (ctl.shift) begin
      status <= nbr.status;
    end
  end

  // Address and length are only meaningful once the record is used.
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      addr <= wr_data.addr;
      len  <= wr_data.len;
    end else if (ctl.shift) begin
      addr <= nbr.addr;
      len  <= nbr.len;
    end
  end

  assign rec = '{status: status, addr: addr, len: len};

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator. The free extents live in a ring of FREE_SLOTS cells kept in
// address order, and the allocation records in a ring of RECORD_SLOTS cells; each pass
// rotates a ring by one cell per cycle past the controller, which reads the head cell and,
// for the free ring, writes the tail. A query makes one search rotation of the free ring;
// allocate and free may add one search rotation of the record ring and one editing
// rotation of the free ring. One item is processed at a time; the next input transfer is
// taken while an earlier result still waits in the output register.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ffha_in_if.sink     in_ch,
  ffha_out_if.source  out_ch
);

  state_t state, state_next;

  logic [SCAN_W-1:0] cnt;
  logic [FCNT_W-1:0] f_pos;
  logic [RIDX_W-1:0] r_pos;
  logic              last_f, last_r;

  // Rings.
  ext_t     fring [FREE_SLOTS];
  rec_t     rring [RECORD_SLOTS];
  ext_t     f_o;
  logic     f_shift, r_shift, r_wr;
  rec_t     r_wr_data;
  logic [RIDX_W-1:0] r_wr_idx;

  // Item registers.
  in_item_t          item;
  logic [NEED_W-1:0] need;
  logic [START_W-1:0] hdr_addr;
  logic [LEN_W-1:0]  largest;

  // Free search results.
  logic              found;
  logic [FCNT_W-1:0] fit_idx;
  logic [START_W-1:0] fit_start;
  logic [LEN_W-1:0]  fit_len;
  logic              pos_found;
  logic [FCNT_W-1:0] pos_idx;
  ext_t              prv, nxt;

  // Record search results.
  logic              m_found, u_found, d_found;
  logic [RIDX_W-1:0] m_idx, u_idx, d_idx;
  rec_t              m_rec;

  // Edit command.
  logic              mod_en, rem_en, ins_en;
  logic [FCNT_W-1:0] e_m, e_r;
  ext_t              e_val;
  ext_t              carry_ext;
  logic [FCNT_W-1:0] free_count;

  // Result.
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [LEN_W-1:0]    res_granted;
  logic                out_valid;
  out_item_t           out_data;

  // Decision signals.
  logic [START_W-1:0] payload;
  logic [START_W-1:0] key;
  logic               range_bad;
  logic               rsel_ok, split, jp, jn, free_full, edit_go;
  logic [RIDX_W-1:0]  k_idx;
  logic [STATUS_W-1:0] chk_status, dec_status;
  logic               d_mod, d_rem, d_ins, d_inc, d_dec;
  logic [FCNT_W-1:0]  d_m, d_r;
  ext_t               d_val;
  logic               accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign f_pos  = FCNT_W'(cnt);
  assign r_pos  = RIDX_W'(cnt);
  assign last_f = (cnt == SCAN_W'(FREE_SLOTS - 1));
  assign last_r = (cnt == SCAN_W'(RECORD_SLOTS - 1));

  // Free extent ring: cell 0 is the head, the controller feeds the last cell.
  for (genvar j = 0; j < FREE_SLOTS; j++) begin : g_free
    ext_t init_j;
    ext_t nbr_j;
    assign init_j = (j == 0) ?
                    ext_t'{valid: 1'b1, start: '0, len: LEN_W'(HEAP_BYTES - HEADER_BYTES)} :
                    ext_t'('0);
    assign nbr_j  = (j == FREE_SLOTS - 1) ? f_o : fring[(j + 1) % FREE_SLOTS];
    ffha_free_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .init  (init_j),
      .shift (f_shift),
      .nbr   (nbr_j),
      .ext   (fring[j])
    );
  end

  // Record ring: a pure rotation, with a direct write into one cell.
  for (genvar j = 0; j < RECORD_SLOTS; j++) begin : g_rec
    rec_ctl_t ctl_j;
    assign ctl_j = '{shift: r_shift, write: r_wr && (r_wr_idx == RIDX_W'(j))};
    ffha_rec_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl_j),
      .nbr     (rring[(j + 1) % RECORD_SLOTS]),
      .wr_data (r_wr_data),
      .rec     (rring[j])
    );
  end

  // Decisions from the search results.
  always_comb begin
    payload   = START_W'(fit_start + START_W'(HEADER_BYTES));
    key       = (item.func == FUNC_ALLOC) ? payload : START_W'(item.ptr);
    range_bad = (32'(item.ptr) >= 32'(HEAP_BYTES));
    rsel_ok   = m_found || u_found || d_found;
    k_idx     = m_found ? m_idx : (u_found ? u_idx : d_idx);
    split     = SUM_W'(fit_len) > (SUM_W'(HEADER_BYTES) + SUM_W'(need));
    jp = prv.valid && ((SUM_W'(prv.start) + SUM_W'(HEADER_BYTES) + SUM_W'(prv.len))
                       == SUM_W'(hdr_addr));
    jn = nxt.valid && ((SUM_W'(hdr_addr) + SUM_W'(HEADER_BYTES) + SUM_W'(m_rec.len))
                       == SUM_W'(nxt.start));
    free_full = !jp && !jn && (free_count >= FCNT_W'(FREE_SLOTS));

    if (item.func == FUNC_ALLOC) begin
      chk_status = found ? STAT_OK : STAT_NOFIT;
    end else if (item.func == FUNC_FREE && range_bad) begin
      chk_status = STAT_RANGE;
    end else begin
      chk_status = STAT_OK;
    end

    d_mod = 1'b0;
    d_rem = 1'b0;
    d_ins = 1'b0;
    d_inc = 1'b0;
    d_dec = 1'b0;
    d_m   = '0;
    d_r   = '0;
    d_val = '0;
    dec_status = STAT_OK;
    r_wr_idx   = k_idx;
    r_wr_data  = '{status: REC_LIVE, addr: payload, len: fit_len};
    edit_go    = 1'b0;

    if (item.func == FUNC_ALLOC) begin
      // Split the extent, or hand over all of it.
      edit_go    = rsel_ok;
      dec_status = rsel_ok ? STAT_OK : STAT_FULL;
      if (split) begin
        d_mod = 1'b1;
        d_m   = fit_idx;
        d_val = '{valid: 1'b1,
                  start: START_W'(SUM_W'(payload) + SUM_W'(need)),
                  len:   LEN_W'(SUM_W'(fit_len) - SUM_W'(HEADER_BYTES) - SUM_W'(need))};
        r_wr_data.len = LEN_W'(need);
      end else begin
        d_rem = 1'b1;
        d_r   = fit_idx;
        d_dec = 1'b1;
      end
    end else begin
      // Free: validate, then coalesce with the neighbors.
      r_wr_idx  = m_idx;
      r_wr_data = '{status: REC_FREED, addr: m_rec.addr, len: m_rec.len};
      if (!m_found) begin
        dec_status = STAT_UNKNOWN;
      end else if (m_rec.status == REC_FREED) begin
        dec_status = STAT_DOUBLE;
      end else if (free_full) begin
        dec_status = STAT_FULL;
      end else begin
        edit_go = 1'b1;
      end
      if (jp && jn) begin
        d_mod = 1'b1;
        d_m   = pos_idx - 1'b1;
        d_val = '{valid: 1'b1, start: prv.start,
                  len: LEN_W'(SUM_W'(prv.len) + SUM_W'(m_rec.len) + SUM_W'(nxt.len)
                              + SUM_W'(2 * HEADER_BYTES))};
        d_rem = 1'b1;
        d_r   = pos_idx;
        d_dec = 1'b1;
      end else if (jp) begin
        d_mod = 1'b1;
        d_m   = pos_idx - 1'b1;
        d_val = '{valid: 1'b1, start: prv.start,
                  len: LEN_W'(SUM_W'(prv.len) + SUM_W'(m_rec.len) + SUM_W'(HEADER_BYTES))};
      end else if (jn) begin
        d_mod = 1'b1;
        d_m   = pos_idx;
        d_val = '{valid: 1'b1, start: hdr_addr,
                  len: LEN_W'(SUM_W'(nxt.len) + SUM_W'(m_rec.len) + SUM_W'(HEADER_BYTES))};
      end else begin
        d_mod = 1'b1;
        d_ins = 1'b1;
        d_m   = pos_idx;
        d_val = '{valid: 1'b1, start: hdr_addr, len: m_rec.len};
        d_inc = 1'b1;
      end
    end
  end

  // Tail feed of the free ring: rotate, or rewrite the table while it goes around.
  always_comb begin
    f_o = fring[0];
    if (state == S_FEDIT) begin
      if (mod_en && f_pos == e_m) begin
        f_o = e_val;
      end else if (rem_en && f_pos >= e_r) begin
        f_o = last_f ? '0 : fring[1];
      end else if (ins_en && f_pos > e_m) begin
        f_o = carry_ext;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_FSEARCH;
      end
      S_FSEARCH: begin
        if (last_f) state_next = S_FCHECK;
      end
      S_FCHECK: begin
        if (item.func == FUNC_ALLOC) begin
          state_next = found ? S_RSEARCH : S_DONE;
        end else if (item.func == FUNC_FREE) begin
          state_next = range_bad ? S_DONE : S_RSEARCH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RSEARCH: begin
        if (last_r) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = edit_go ? S_FEDIT : S_DONE;
      end
      S_FEDIT: begin
        if (last_f) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ch.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    in_ch.ready = (state == S_IDLE);
    f_shift     = (state == S_FSEARCH) || (state == S_FEDIT);
    r_shift     = (state == S_RSEARCH);
    r_wr        = (state == S_DECIDE) && edit_go;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= FCNT_W'(1);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECIDE && edit_go) begin
        if (d_inc) free_count <= free_count + 1'b1;
        if (d_dec) free_count <= free_count - 1'b1;
      end
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_FSEARCH || state == S_RSEARCH || state == S_FEDIT) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item        <= in_ch.data;
          need        <= (NEED_W'(in_ch.data.req_bytes) + NEED_W'(ALIGN_MASK + 1))
                         & ~NEED_W'(ALIGN_MASK);
          hdr_addr    <= START_W'(in_ch.data.ptr) - START_W'(HEADER_BYTES);
          largest     <= '0;
          found       <= 1'b0;
          pos_found   <= 1'b0;
          pos_idx     <= FCNT_W'(FREE_SLOTS);
          prv         <= '0;
          nxt         <= '0;
          m_found     <= 1'b0;
          u_found     <= 1'b0;
          d_found     <= 1'b0;
          res_status  <= STAT_OK;
          res_addr    <= '0;
          res_granted <= '0;
        end
      end
      S_FSEARCH: begin
        // Walk the extents: largest, first fit, and sorted position of the freed chunk.
        if (fring[0].valid && fring[0].len > largest) largest <= fring[0].len;
        if (!found && fring[0].valid && NEED_W'(fring[0].len) >= need) begin
          found     <= 1'b1;
          fit_idx   <= f_pos;
          fit_start <= fring[0].start;
          fit_len   <= fring[0].len;
        end
        if (!pos_found) begin
          if (!fring[0].valid || fring[0].start > hdr_addr) begin
            pos_found <= 1'b1;
            pos_idx   <= f_pos;
            nxt       <= fring[0];
          end else begin
            prv <= fring[0];
          end
        end
      end
      S_FCHECK: begin
        res_status <= chk_status;
      end
      S_RSEARCH: begin
        // Walk the records: matching address, first unused, first freed.
        if (!m_found && rring[0].status != REC_UNUSED && rring[0].addr == key) begin
          m_found <= 1'b1;
          m_idx   <= r_pos;
          m_rec   <= rring[0];
        end
        if (!u_found && rring[0].status == REC_UNUSED) begin
          u_found <= 1'b1;
          u_idx   <= r_pos;
        end
        if (!d_found && rring[0].status == REC_FREED) begin
          d_found <= 1'b1;
          d_idx   <= r_pos;
        end
      end
      S_DECIDE: begin
        res_status <= dec_status;
        mod_en     <= d_mod;
        rem_en     <= d_rem;
        ins_en     <= d_ins;
        e_m        <= d_m;
        e_r        <= d_r;
        e_val      <= d_val;
        if (edit_go) begin
          largest <= '0;
          if (item.func == FUNC_ALLOC) begin
            res_addr    <= ADDR_W'(payload);
            res_granted <= LEN_W'(item.req_bytes);
          end
        end
      end
      S_FEDIT: begin
        // Largest is taken over the rewritten table.
        carry_ext <= fring[0];
        if (f_o.valid && f_o.len > largest) largest <= f_o.len;
      end
      S_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_data <= '{status: res_status, addr: res_addr,
                        granted_bytes: res_granted, largest_free: largest};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ffha_pkg::*;

  // Code for the query operation; the package names only allocate and free.
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  ffha_in_if  in_ch ();
  ffha_out_if out_ch ();

  first_fit_heap_allocator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the heap tables.
  longint ext_start [FREE_SLOTS];
  longint ext_len [FREE_SLOTS];
  int     ext_count;
  longint grant_addr [RECORD_SLOTS];
  longint grant_len [RECORD_SLOTS];
  logic [1:0] grant_state [RECORD_SLOTS];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  longint    live_ptrs [$];
  longint    freed_ptrs [$];
  int        errors;
  int        cycles;
  bit        stimulus_done;
  bit        in_taken;
  bit        out_taken;

  function automatic void heap_reset();
    for (int i = 0; i < FREE_SLOTS; i++) begin
      ext_start[i] = 0;
      ext_len[i] = 0;
    end
    for (int k = 0; k < RECORD_SLOTS; k++) begin
      grant_addr[k] = 0;
      grant_len[k] = 0;
      grant_state[k] = REC_UNUSED;
    end
    ext_len[0] = HEAP_BYTES - HEADER_BYTES;
    ext_count = 1;
  endfunction

  function automatic longint largest_extent();
    longint best;
    best = 0;
    for (int i = 0; i < ext_count; i++)
      if (ext_len[i] > best) best = ext_len[i];
    return best;
  endfunction

  function automatic void drop_extent(int i);
    for (int j = i; j < ext_count - 1; j++) begin
      ext_start[j] = ext_start[j + 1];
      ext_len[j] = ext_len[j + 1];
    end
    ext_count--;
  endfunction

  function automatic int grant_lookup(longint a);
    for (int k = 0; k < RECORD_SLOTS; k++)
      if (grant_state[k] != REC_UNUSED && grant_addr[k] == a) return k;
    return -1;
  endfunction

  function automatic logic [STATUS_W-1:0] heap_allocate(longint req, output longint addr);
    longint need, payload;
    int i, k;
    addr = 0;
    need = (req + 1 + ALIGN_MASK) & ~longint'(ALIGN_MASK);
    for (i = 0; i < ext_count; i++)
      if (ext_len[i] >= need) break;
    if (i >= ext_count) return STAT_NOFIT;
    payload = ext_start[i] + HEADER_BYTES;
    k = grant_lookup(payload);
    for (int j = 0; k < 0 && j < RECORD_SLOTS; j++)
      if (grant_state[j] == REC_UNUSED) k = j;
    for (int j = 0; k < 0 && j < RECORD_SLOTS; j++)
      if (grant_state[j] == REC_FREED) k = j;
    if (k < 0) return STAT_FULL;
    // Split when the remainder can hold a header and more, else hand over the extent.
    if (ext_len[i] > HEADER_BYTES + need) begin
      grant_len[k] = need;
      ext_start[i] += HEADER_BYTES + need;
      ext_len[i] -= HEADER_BYTES + need;
    end else begin
      grant_len[k] = ext_len[i];
      drop_extent(i);
    end
    grant_addr[k] = payload;
    grant_state[k] = REC_LIVE;
    addr = payload;
    return STAT_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] heap_release(longint p);
    longint h, len;
    int i, k;
    bit join_prev, join_next;
    if (p >= HEAP_BYTES) return STAT_RANGE;
    k = grant_lookup(p);
    if (k < 0) return STAT_UNKNOWN;
    if (grant_state[k] == REC_FREED) return STAT_DOUBLE;
    h = p - HEADER_BYTES;
    len = grant_len[k];
    for (i = 0; i < ext_count; i++)
      if (ext_start[i] > h) break;
    join_prev = i > 0 && ext_start[i - 1] + HEADER_BYTES + ext_len[i - 1] == h;
    join_next = i < ext_count && h + HEADER_BYTES + len == ext_start[i];
    // Coalesce with free neighbors, or insert a new extent in address order.
    if (join_prev && join_next) begin
      ext_len[i - 1] += 2 * HEADER_BYTES + len + ext_len[i];
      drop_extent(i);
    end else if (join_prev) begin
      ext_len[i - 1] += HEADER_BYTES + len;
    end else if (join_next) begin
      ext_start[i] = h;
      ext_len[i] += HEADER_BYTES + len;
    end else begin
      if (ext_count >= FREE_SLOTS) return STAT_FULL;
      for (int j = ext_count; j > i; j--) begin
        ext_start[j] = ext_start[j - 1];
        ext_len[j] = ext_len[j - 1];
      end
      ext_start[i] = h;
      ext_len[i] = len;
      ext_count++;
    end
    grant_state[k] = REC_FREED;
    return STAT_OK;
  endfunction

  function automatic out_item_t heap_predict(in_item_t it);
    out_item_t r;
    longint a;
    r = '0;
    if (it.func == FUNC_ALLOC) begin
      r.status = heap_allocate(longint'(it.req_bytes), a);
      if (r.status == STAT_OK) begin
        r.addr = a[ADDR_W-1:0];
        r.granted_bytes = it.req_bytes;
        live_ptrs.push_back(a);
      end
    end else if (it.func == FUNC_FREE) begin
      r.status = heap_release(longint'(it.ptr));
      if (r.status == STAT_OK) freed_ptrs.push_back(longint'(it.ptr));
    end else begin
      r.status = STAT_OK;
    end
    r.largest_free = LEN_W'(largest_extent());
    return r;
  endfunction

  // Input driver: random gap before each item, change on the falling edge.
  int send_gap;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_gap = 0;
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_ch.valid <= 1'b0;
        send_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end else if (!in_ch.valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          in_ch.data <= pending_items.pop_front();
          in_ch.valid <= 1'b1;
        end
      end
    end
  end

  // Predict on each accepted input transfer.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(heap_predict(in_ch.data));
      in_taken = 1'b1;
    end
  end

  // Output side: random stalls on ready after each result transfer.
  int stall;
  initial begin
    out_ch.ready = 1'b0;
    stall = 0;
    out_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end
    if (stall > 0) begin
      stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      out_taken = 1'b1;
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        end
        if (got.addr !== exp_r.addr) begin
          errors++;
          $display("%0t: addr expected %0d actual %0d", $time, exp_r.addr, got.addr);
        end
        if (got.granted_bytes !== exp_r.granted_bytes) begin
          errors++;
          $display("%0t: granted_bytes expected %0d actual %0d", $time,
                   exp_r.granted_bytes, got.granted_bytes);
        end
        if (got.largest_free !== exp_r.largest_free) begin
          errors++;
          $display("%0t: largest_free expected %0d actual %0d", $time,
                   exp_r.largest_free, got.largest_free);
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [FUNC_W-1:0] f, longint req, longint p);
    in_item_t it;
    it.func = f;
    it.req_bytes = req[REQ_W-1:0];
    it.ptr = p[PTR_W-1:0];
    return it;
  endfunction

  // Pick a pointer for a free: mostly live grants, some stale, some junk.
  function automatic longint pick_ptr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && live_ptrs.size() > 0)
      return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
    if (sel < 8 && freed_ptrs.size() > 0)
      return freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
    if (sel == 8) return $urandom_range(0, (1 << PTR_W) - 1);
    return $urandom_range(0, HEAP_BYTES / 8 - 1) * 8;
  endfunction

  function automatic longint pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom_range(0, (1 << REQ_W) - 1);
    if (sel == 1) return $urandom_range(0, HEAP_BYTES);
    if (sel < 5) return $urandom_range(0, 65535);
    return $urandom_range(0, 4095);
  endfunction

  initial begin
    int func_sel;
    errors = 0;
    cycles = 0;
    stimulus_done = 0;
    heap_reset();
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: queries, no fit, range, unknown, double free, exact fit, merges.
    pending_items.push_back(make_item(FUNC_QUERY, 0, 0));
    pending_items.push_back(make_item(FUNC_SPARE, (1 << REQ_W) - 1, (1 << PTR_W) - 1));
    pending_items.push_back(make_item(FUNC_ALLOC, (1 << REQ_W) - 1, 0));
    pending_items.push_back(make_item(FUNC_ALLOC, HEAP_BYTES, 0));
    pending_items.push_back(make_item(FUNC_FREE, 0, (1 << PTR_W) - 1));
    pending_items.push_back(make_item(FUNC_FREE, 0, HEAP_BYTES));
    pending_items.push_back(make_item(FUNC_FREE, 0, 16));
    pending_items.push_back(make_item(FUNC_ALLOC, 0, 0));
    pending_items.push_back(make_item(FUNC_ALLOC, 7, 0));
    pending_items.push_back(make_item(FUNC_ALLOC, 100, 0));
    pending_items.push_back(make_item(FUNC_FREE, 0, 40));
    pending_items.push_back(make_item(FUNC_FREE, 0, 40));
    pending_items.push_back(make_item(FUNC_FREE, 0, 16));
    pending_items.push_back(make_item(FUNC_FREE, 0, 64));
    pending_items.push_back(make_item(FUNC_ALLOC, HEAP_BYTES - HEADER_BYTES - 1, 0));
    pending_items.push_back(make_item(FUNC_QUERY, 0, 0));
    pending_items.push_back(make_item(FUNC_FREE, 0, 16));
    pending_items.push_back(make_item(FUNC_ALLOC, 0, 0));
    // Wait for the directed part so pointer picks see real grants.
    wait (pending_items.size() == 0 && expected_results.size() == 0);

    // Random: bursts of allocations to fill the record table, frees to fragment.
    for (int n = 0; n < 500; n++) begin
      func_sel = $urandom_range(0, 19);
      if (func_sel < 10)
        pending_items.push_back(make_item(FUNC_ALLOC, pick_size(), $urandom));
      else if (func_sel < 18)
        pending_items.push_back(make_item(FUNC_FREE, $urandom, pick_ptr()));
      else
        pending_items.push_back(make_item(func_sel[0] ? FUNC_SPARE : FUNC_QUERY,
                                          $urandom, $urandom));
      if (n % 20 == 19)
        wait (pending_items.size() == 0 && expected_results.size() == 0);
    end

    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
